FILE: rtl/core/hcb_pkg.sv
// Shared types and codes for the Huffman code builder.
// Used by hcb_ctrl, hcb_dp and huffman_code_builder; no dependencies.
`timescale 1ns / 1ps
package hcb_pkg;

  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  localparam int IN_W  = 16;
  localparam int OUT_W = 88;

  typedef enum logic [5:0] {
    C_NOP, C_CNT_RD, C_CNT_UPD, C_CODE_RD, C_OUT_PLAIN, C_OUT_READ,
    C_B_INIT, C_SCAN_RD, C_SCAN_LEAF,
    C_PUSH_UP, C_PUSH_E, C_PUSH_F, C_PUSH_END,
    C_MERGE_INIT, C_HEAP_RD0, C_POP_T, C_POP_TF, C_POP_L, C_POP_LF,
    C_SINK_L, C_SINK_C, C_SINK_CF, C_SINK_R, C_SINK_RF, C_SINK_CMP, C_SINK_END,
    C_POP_A, C_MERGE_NEW,
    C_WALK_INIT, C_WALK_POP, C_WALK_E, C_WALK_LEAF, C_WALK_PUSH1, C_WALK_PUSH0,
    C_B_DONE
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic hist_hit;
    logic leaves_zero;
    logic pos_zero;
    logic push_stop;
    logic merge_go;
    logic size_one;
    logic sink_go;
    logic has_right;
    logic sink_stop;
    logic sp_zero;
    logic is_leaf;
  } sts_t;

endpackage

FILE: rtl/core/hcb_ctrl.sv
// Sequencer for count, read and build beats of the Huffman code builder.
// Issues one datapath command per cycle; depends on hcb_pkg.
`timescale 1ns / 1ps
module hcb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [1:0]    in_op,
  input  hcb_pkg::sts_t sts,
  output hcb_pkg::cmd_t cmd,
  output logic          in_rdy
);
  import hcb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_CNT_RD, S_CNT_UPD, S_OUT, S_RD_RD, S_RD_OUT,
    S_B_INIT, S_SCAN, S_SCAN_CHK,
    S_PUSH_CHK, S_PUSH_E, S_PUSH_F, S_PUSH_END,
    S_B_CHK, S_MERGE, S_POP_RD, S_POP_T, S_POP_TF, S_POP_L, S_POP_LF,
    S_SINK, S_SINK_C, S_SINK_CF, S_SINK_R, S_SINK_RF, S_SINK_CMP, S_SINK_END,
    S_POP_END, S_ROOT, S_WALK, S_WALK_E, S_WALK_LEAF, S_WALK_R, S_WALK_L,
    S_B_DONE
  } state_t;

  state_t state_r, state_nxt, ret_state;
  logic   pop2_r, pop2_nxt;
  logic   ret_merge_r, ret_merge_nxt;

  assign in_rdy    = (state_r == S_IDLE) && sts.out_free;
  assign ret_state = ret_merge_r ? S_MERGE : S_SCAN;

  always_comb begin
    state_nxt     = state_r;
    pop2_nxt      = pop2_r;
    ret_merge_nxt = ret_merge_r;
    cmd           = C_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_COUNT: state_nxt = S_CNT_RD;
            OP_BUILD: state_nxt = S_B_INIT;
            OP_READ:  state_nxt = S_RD_RD;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_CNT_RD:  begin cmd = C_CNT_RD;    state_nxt = S_CNT_UPD; end
      S_CNT_UPD: begin cmd = C_CNT_UPD;   state_nxt = S_OUT;     end
      S_OUT:     begin cmd = C_OUT_PLAIN; state_nxt = S_IDLE;    end
      S_RD_RD:   begin cmd = C_CODE_RD;   state_nxt = S_RD_OUT;  end
      S_RD_OUT:  begin cmd = C_OUT_READ;  state_nxt = S_IDLE;    end
      S_B_INIT: begin
        cmd           = C_B_INIT;
        ret_merge_nxt = 1'b0;
        pop2_nxt      = 1'b0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd       = C_SCAN_RD;
        state_nxt = sts.scan_done ? S_B_CHK : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd       = C_SCAN_LEAF;
        state_nxt = sts.hist_hit ? S_PUSH_CHK : S_SCAN;
      end
      S_PUSH_CHK: begin
        cmd       = C_PUSH_UP;
        state_nxt = sts.pos_zero ? S_PUSH_END : S_PUSH_E;
      end
      S_PUSH_E: begin cmd = C_PUSH_E; state_nxt = S_PUSH_F; end
      S_PUSH_F: begin
        cmd       = C_PUSH_F;
        state_nxt = sts.push_stop ? ret_state : S_PUSH_CHK;
      end
      S_PUSH_END: begin cmd = C_PUSH_END; state_nxt = ret_state; end
      S_B_CHK: begin
        cmd       = C_MERGE_INIT;
        state_nxt = sts.leaves_zero ? S_B_DONE : S_MERGE;
      end
      S_MERGE: begin
        cmd       = C_HEAP_RD0;
        state_nxt = sts.merge_go ? S_POP_T : S_ROOT;
      end
      S_POP_RD: begin cmd = C_HEAP_RD0; state_nxt = S_POP_T; end
      S_POP_T:  begin cmd = C_POP_T;    state_nxt = S_POP_TF; end
      S_POP_TF: begin
        cmd       = C_POP_TF;
        state_nxt = sts.size_one ? S_POP_END : S_POP_L;
      end
      S_POP_L:  begin cmd = C_POP_L;  state_nxt = S_POP_LF; end
      S_POP_LF: begin cmd = C_POP_LF; state_nxt = S_SINK;   end
      S_SINK: begin
        cmd       = C_SINK_L;
        state_nxt = sts.sink_go ? S_SINK_C : S_SINK_END;
      end
      S_SINK_C: begin cmd = C_SINK_C; state_nxt = S_SINK_CF; end
      S_SINK_CF: begin
        cmd       = C_SINK_CF;
        state_nxt = sts.has_right ? S_SINK_R : S_SINK_CMP;
      end
      S_SINK_R:  begin cmd = C_SINK_R;  state_nxt = S_SINK_RF;  end
      S_SINK_RF: begin cmd = C_SINK_RF; state_nxt = S_SINK_CMP; end
      S_SINK_CMP: begin
        cmd       = C_SINK_CMP;
        state_nxt = sts.sink_stop ? S_POP_END : S_SINK;
      end
      S_SINK_END: begin cmd = C_SINK_END; state_nxt = S_POP_END; end
      S_POP_END: begin
        if (!pop2_r) begin
          cmd       = C_POP_A;
          pop2_nxt  = 1'b1;
          state_nxt = S_POP_RD;
        end else begin
          cmd           = C_MERGE_NEW;
          pop2_nxt      = 1'b0;
          ret_merge_nxt = 1'b1;
          state_nxt     = S_PUSH_CHK;
        end
      end
      S_ROOT: begin cmd = C_WALK_INIT; state_nxt = S_WALK; end
      S_WALK: begin
        if (sts.sp_zero) begin
          state_nxt = S_B_DONE;
        end else begin
          cmd       = C_WALK_POP;
          state_nxt = S_WALK_E;
        end
      end
      S_WALK_E: begin
        cmd       = C_WALK_E;
        state_nxt = sts.is_leaf ? S_WALK_LEAF : S_WALK_R;
      end
      S_WALK_LEAF: begin cmd = C_WALK_LEAF;  state_nxt = S_WALK;   end
      S_WALK_R:    begin cmd = C_WALK_PUSH1; state_nxt = S_WALK_L; end
      S_WALK_L:    begin cmd = C_WALK_PUSH0; state_nxt = S_WALK;   end
      S_B_DONE:    begin cmd = C_B_DONE;     state_nxt = S_IDLE;   end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pop2_r      <= 1'b0;
      ret_merge_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pop2_r      <= pop2_nxt;
      ret_merge_r <= ret_merge_nxt;
    end
  end

endmodule

FILE: rtl/core/hcb_dp.sv
// Datapath: histogram, node store, heap, walk stack, code table, result register.
// Executes hcb_ctrl commands; depends on hcb_pkg.
`timescale 1ns / 1ps
module hcb_dp #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_BITS    = 32,
  parameter int MAX_CODE_BITS = 64,
  parameter int NODE_SLOTS    = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hcb_pkg::cmd_t             cmd,
  input  logic                      in_fire,
  input  logic [7:0]                in_sym,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic [hcb_pkg::OUT_W-1:0] out_data,
  output hcb_pkg::sts_t             sts
);
  import hcb_pkg::*;

  localparam int NODE_W     = $clog2(NODE_SLOTS);
  localparam int HEAP_W     = $clog2(SYMBOLS);
  localparam int SYM_W      = HEAP_W;
  localparam int LEN_W      = $clog2(MAX_CODE_BITS + 1);
  localparam int FREQ_W     = COUNT_BITS + 8;
  localparam int MAX_LEAVES = (NODE_SLOTS + 1) / 2;
  localparam int KW         = 1 + LEN_W + MAX_CODE_BITS + NODE_W;
  localparam int TW         = LEN_W + MAX_CODE_BITS;

  // memories
  logic [COUNT_BITS-1:0]    hist_m  [SYMBOLS];
  logic [FREQ_W-1:0]        freq_m  [NODE_SLOTS];
  logic [2*NODE_W-1:0]      kids_m  [NODE_SLOTS];
  logic [SYM_W-1:0]         nsym_m  [NODE_SLOTS];
  logic [NODE_W-1:0]        heap_m  [SYMBOLS];
  logic [KW-1:0]            stk_m   [NODE_SLOTS];
  logic [TW-1:0]            code_m  [SYMBOLS];

  logic                  h_re, h_we;
  logic [SYM_W-1:0]      h_ra, h_wa;
  logic [COUNT_BITS-1:0] h_wd, h_rd_r;
  logic                  f_re, f_we;
  logic [NODE_W-1:0]     f_ra, f_wa;
  logic [FREQ_W-1:0]     f_wd, f_rd_r;
  logic                  c_re, kc_we, ns_we;
  logic [NODE_W-1:0]     c_ra, kc_wa, ns_wa;
  logic [2*NODE_W-1:0]   kc_wd, c_kids_r;
  logic [SYM_W-1:0]      ns_wd, c_nsym_r;
  logic                  p_re, p_we;
  logic [HEAP_W-1:0]     p_ra, p_wa;
  logic [NODE_W-1:0]     p_wd, p_rd_r;
  logic                  k_re, k_we;
  logic [NODE_W-1:0]     k_ra, k_wa;
  logic [KW-1:0]         k_wd, k_rd_r;
  logic                  t_re, t_we;
  logic [SYM_W-1:0]      t_ra, t_wa;
  logic [TW-1:0]         t_wd, t_rd_r;

  // control state
  logic [SYMBOLS-1:0] h_vld_r, c_vld_r;
  logic               sat_r;
  logic               out_valid_r;

  // payload registers
  logic [7:0]              sym_r;
  logic [OUT_W-1:0]        out_data_r;
  logic [NODE_W:0]         n_r;
  logic [SYM_W:0]          s_r;
  logic [HEAP_W:0]         size_r;
  logic [NODE_W:0]         next_r;
  logic [HEAP_W-1:0]       pos_r, ch_r;
  logic [NODE_W-1:0]       item_r, e_r, c_r, c2_r, top_r, a_r;
  logic [FREQ_W-1:0]       item_f_r, cf_r, top_f_r, a_f_r;
  logic [NODE_W:0]         sp_r;
  logic [MAX_CODE_BITS-1:0] w_bits_r;
  logic [LEN_W-1:0]        w_len_r;
  logic                    w_over_r;

  logic                    sym_ok, cnt_sat;
  logic [COUNT_BITS-1:0]   cnt_val;
  logic [SYM_W-1:0]        sym_a, s_a;
  logic [HEAP_W-1:0]       pos_up;
  logic [HEAP_W+1:0]       ch_l, ch_rgt;
  logic [FREQ_W-1:0]       sum_f;
  logic                    over_n, push_bit;
  logic [LEN_W-1:0]        len_n;
  logic [MAX_CODE_BITS-1:0] bits_n;
  logic [NODE_W-1:0]       child;
  logic [1:0]              plain_stat;
  logic                    rd_present;

  assign sym_ok   = {1'b0, sym_r} < 9'(SYMBOLS);
  assign sym_a    = sym_r[SYM_W-1:0];
  assign s_a      = s_r[SYM_W-1:0];
  assign cnt_val  = h_vld_r[sym_a] ? h_rd_r : '0;
  assign cnt_sat  = (cnt_val == {COUNT_BITS{1'b1}});
  assign pos_up   = (pos_r - HEAP_W'(1)) >> 1;
  assign ch_l     = {1'b0, pos_r, 1'b1};
  assign ch_rgt   = ch_l + (HEAP_W+2)'(1);
  assign sum_f    = a_f_r + top_f_r;
  assign push_bit = (cmd == C_WALK_PUSH1);
  assign child    = push_bit ? c_kids_r[2*NODE_W-1:NODE_W] : c_kids_r[NODE_W-1:0];
  assign over_n   = w_over_r || (w_len_r >= LEN_W'(MAX_CODE_BITS));
  assign len_n    = over_n ? w_len_r : w_len_r + LEN_W'(1);
  assign bits_n   = over_n ? '0 : {w_bits_r[MAX_CODE_BITS-2:0], push_bit};
  assign plain_stat = sat_r ? STAT_SAT : STAT_OK;
  assign rd_present = sym_ok && c_vld_r[sym_a];

  assign sts.out_free    = !out_valid_r || out_tready;
  assign sts.scan_done   = (s_r == (SYM_W+1)'(SYMBOLS)) || (n_r == (NODE_W+1)'(MAX_LEAVES));
  assign sts.hist_hit    = h_vld_r[s_a] && (h_rd_r != '0);
  assign sts.leaves_zero = (n_r == '0);
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.push_stop   = (item_f_r >= f_rd_r);
  assign sts.merge_go    = (size_r > (HEAP_W+1)'(1)) && (next_r < (NODE_W+1)'(NODE_SLOTS));
  assign sts.size_one    = (size_r == (HEAP_W+1)'(1));
  assign sts.sink_go     = ({1'b0, pos_r} < (size_r >> 1));
  assign sts.has_right   = (ch_rgt < (HEAP_W+2)'(size_r));
  assign sts.sink_stop   = (item_f_r <= cf_r);
  assign sts.sp_zero     = (sp_r == '0);
  assign sts.is_leaf     = ({1'b0, k_rd_r[NODE_W-1:0]} < n_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    h_re = 1'b0; h_ra = '0; h_we = 1'b0; h_wa = '0; h_wd = '0;
    f_re = 1'b0; f_ra = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
    c_re = 1'b0; c_ra = '0; kc_we = 1'b0; kc_wa = '0; kc_wd = '0;
    ns_we = 1'b0; ns_wa = '0; ns_wd = '0;
    p_re = 1'b0; p_ra = '0; p_we = 1'b0; p_wa = '0; p_wd = '0;
    k_re = 1'b0; k_ra = '0; k_we = 1'b0; k_wa = '0; k_wd = '0;
    t_re = 1'b0; t_ra = '0; t_we = 1'b0; t_wa = '0; t_wd = '0;
    unique case (cmd)
      C_CNT_RD: begin h_re = 1'b1; h_ra = sym_a; end
      C_CNT_UPD: begin
        h_we = sym_ok && !cnt_sat;
        h_wa = sym_a;
        h_wd = cnt_val + COUNT_BITS'(1);
      end
      C_CODE_RD: begin t_re = 1'b1; t_ra = sym_a; end
      C_SCAN_RD: begin h_re = 1'b1; h_ra = s_a; end
      C_SCAN_LEAF: begin
        f_we  = sts.hist_hit; f_wa = NODE_W'(n_r); f_wd = FREQ_W'(h_rd_r);
        ns_we = sts.hist_hit; ns_wa = NODE_W'(n_r); ns_wd = s_a;
      end
      C_PUSH_UP: begin p_re = 1'b1; p_ra = pos_up; end
      C_PUSH_E:  begin f_re = 1'b1; f_ra = p_rd_r; end
      C_PUSH_F: begin
        p_we = 1'b1; p_wa = pos_r;
        p_wd = sts.push_stop ? item_r : e_r;
      end
      C_PUSH_END: begin p_we = 1'b1; p_wa = pos_r; p_wd = item_r; end
      C_HEAP_RD0: begin p_re = 1'b1; p_ra = '0; end
      C_POP_T:    begin f_re = 1'b1; f_ra = p_rd_r; end
      C_POP_TF:   begin p_re = 1'b1; p_ra = HEAP_W'(size_r - (HEAP_W+1)'(1)); end
      C_POP_L:    begin f_re = 1'b1; f_ra = p_rd_r; end
      C_SINK_L:   begin p_re = 1'b1; p_ra = ch_l[HEAP_W-1:0]; end
      C_SINK_C:   begin f_re = 1'b1; f_ra = p_rd_r; end
      C_SINK_CF:  begin p_re = 1'b1; p_ra = ch_rgt[HEAP_W-1:0]; end
      C_SINK_R:   begin f_re = 1'b1; f_ra = p_rd_r; end
      C_SINK_CMP: begin
        p_we = 1'b1; p_wa = pos_r;
        p_wd = sts.sink_stop ? item_r : c_r;
      end
      C_SINK_END: begin p_we = 1'b1; p_wa = pos_r; p_wd = item_r; end
      C_MERGE_NEW: begin
        f_we  = 1'b1; f_wa = NODE_W'(next_r); f_wd = sum_f;
        kc_we = 1'b1; kc_wa = NODE_W'(next_r); kc_wd = {top_r, a_r};
      end
      C_WALK_INIT: begin
        k_we = 1'b1; k_wa = '0;
        k_wd = {1'b0, {LEN_W{1'b0}}, {MAX_CODE_BITS{1'b0}}, p_rd_r};
      end
      C_WALK_POP: begin k_re = 1'b1; k_ra = NODE_W'(sp_r - (NODE_W+1)'(1)); end
      C_WALK_E:   begin c_re = 1'b1; c_ra = k_rd_r[NODE_W-1:0]; end
      C_WALK_LEAF: begin
        t_we = !w_over_r; t_wa = c_nsym_r; t_wd = {w_len_r, w_bits_r};
      end
      C_WALK_PUSH1, C_WALK_PUSH0: begin
        k_we = (sp_r < (NODE_W+1)'(NODE_SLOTS));
        k_wa = NODE_W'(sp_r);
        k_wd = {over_n, len_n, bits_n, child};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) hist_m[h_wa] <= h_wd;
    if (h_re) h_rd_r <= hist_m[h_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) freq_m[f_wa] <= f_wd;
    if (f_re) f_rd_r <= freq_m[f_ra];
  end

  always_ff @(posedge clk) begin
    if (kc_we) kids_m[kc_wa] <= kc_wd;
    if (ns_we) nsym_m[ns_wa] <= ns_wd;
    if (c_re) begin
      c_kids_r <= kids_m[c_ra];
      c_nsym_r <= nsym_m[c_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) heap_m[p_wa] <= p_wd;
    if (p_re) p_rd_r <= heap_m[p_ra];
  end

  always_ff @(posedge clk) begin
    if (k_we) stk_m[k_wa] <= k_wd;
    if (k_re) k_rd_r <= stk_m[k_ra];
  end

  always_ff @(posedge clk) begin
    if (t_we) code_m[t_wa] <= t_wd;
    if (t_re) t_rd_r <= code_m[t_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r     <= '0;
      c_vld_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (h_we) h_vld_r[h_wa] <= 1'b1;
      if (t_we) c_vld_r[t_wa] <= 1'b1;
      unique case (cmd)
        C_CNT_UPD:   if (sym_ok && cnt_sat) sat_r <= 1'b1;
        C_B_INIT:    c_vld_r <= '0;
        C_OUT_PLAIN, C_OUT_READ: out_valid_r <= 1'b1;
        C_B_DONE: begin
          out_valid_r <= 1'b1;
          h_vld_r     <= '0;
          sat_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) sym_r <= in_sym;
    unique case (cmd)
      C_OUT_PLAIN: out_data_r <= {6'd0, plain_stat, 64'd0, 7'd0, 1'b0, sym_r};
      C_OUT_READ: begin
        out_data_r <= {6'd0, plain_stat,
                       rd_present ? 64'(t_rd_r[MAX_CODE_BITS-1:0]) : 64'd0,
                       rd_present ? 7'(t_rd_r[TW-1:MAX_CODE_BITS]) : 7'd0,
                       rd_present, sym_r};
      end
      C_B_DONE: begin
        out_data_r <= {6'd0, (n_r == '0) ? STAT_EMPTY : plain_stat,
                       64'd0, 7'd0, 1'b0, sym_r};
      end
      C_B_INIT: begin
        n_r <= '0;
        s_r <= '0;
      end
      C_SCAN_LEAF: begin
        s_r <= s_r + (SYM_W+1)'(1);
        if (sts.hist_hit) begin
          item_r   <= NODE_W'(n_r);
          item_f_r <= FREQ_W'(h_rd_r);
          pos_r    <= HEAP_W'(n_r);
          n_r      <= n_r + (NODE_W+1)'(1);
        end
      end
      C_PUSH_E: e_r <= p_rd_r;
      C_PUSH_F: if (!sts.push_stop) pos_r <= pos_up;
      C_MERGE_INIT: begin
        size_r <= (HEAP_W+1)'(n_r);
        next_r <= n_r;
      end
      C_POP_T: top_r <= p_rd_r;
      C_POP_TF: begin
        top_f_r <= f_rd_r;
        size_r  <= size_r - (HEAP_W+1)'(1);
      end
      C_POP_L:  item_r <= p_rd_r;
      C_POP_LF: begin
        item_f_r <= f_rd_r;
        pos_r    <= '0;
      end
      C_SINK_C: c_r <= p_rd_r;
      C_SINK_CF: begin
        cf_r <= f_rd_r;
        ch_r <= ch_l[HEAP_W-1:0];
      end
      C_SINK_R: c2_r <= p_rd_r;
      C_SINK_RF: begin
        if (cf_r > f_rd_r) begin
          c_r  <= c2_r;
          cf_r <= f_rd_r;
          ch_r <= ch_r + HEAP_W'(1);
        end
      end
      C_SINK_CMP: if (!sts.sink_stop) pos_r <= ch_r;
      C_POP_A: begin
        a_r   <= top_r;
        a_f_r <= top_f_r;
      end
      C_MERGE_NEW: begin
        item_r   <= NODE_W'(next_r);
        item_f_r <= sum_f;
        pos_r    <= HEAP_W'(size_r);
        size_r   <= size_r + (HEAP_W+1)'(1);
        next_r   <= next_r + (NODE_W+1)'(1);
      end
      C_WALK_INIT: sp_r <= (NODE_W+1)'(1);
      C_WALK_POP:  sp_r <= sp_r - (NODE_W+1)'(1);
      C_WALK_E: begin
        w_bits_r <= k_rd_r[NODE_W +: MAX_CODE_BITS];
        w_len_r  <= k_rd_r[NODE_W+MAX_CODE_BITS +: LEN_W];
        w_over_r <= k_rd_r[KW-1];
      end
      C_WALK_PUSH1, C_WALK_PUSH0: begin
        if (k_we) sp_r <= sp_r + (NODE_W+1)'(1);
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/huffman_code_builder.sv
// Huffman code builder over a byte alphabet: stream ports, controller and datapath.
// Instantiates hcb_ctrl and hcb_dp; depends on hcb_pkg.
`timescale 1ns / 1ps
// One beat is taken at a time. A count beat steps through histogram read,
// increment, result load and idle, a read beat through code read, result
// load and idle, and an unknown operation through result load and idle. A
// build walks the histogram symbol by symbol, sifting each leaf up the heap,
// then merges: each pop sifts the last entry down from the top, each
// insertion sifts up, then codes are assigned node by node. Each node, heap
// and stack memory has a single read port. The histogram and code table
// reset clear at once through per-entry valid bits; no clearing pass.
module huffman_code_builder #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_BITS    = 32,
  parameter int MAX_CODE_BITS = 64,
  parameter int NODE_SLOTS    = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation[1:0], data_byte[9:2], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // symbol[7:0], present[8], code_length[15:9],
                                  // code_bits[79:16], status[81:80], zero
);
  import hcb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  hcb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_op   (in_tdata[1:0]),
    .sts     (sts),
    .cmd     (cmd),
    .in_rdy  (in_tready)
  );

  hcb_dp #(
    .SYMBOLS       (SYMBOLS),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .NODE_SLOTS    (NODE_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_fire    (in_fire),
    .in_sym     (in_tdata[9:2]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .sts        (sts)
  );

endmodule

FILE: tb/huffman_code_builder_test.sv
// Testbench for huffman_code_builder: byte counting, Huffman table builds and code reads.
// Holds its own tree-building predictor and a result checker; depends on hcb_pkg.
`timescale 1ns / 1ps
module huffman_code_builder_test;
  import hcb_pkg::*;

  localparam int NSYM = 256;
  localparam int MAXLEN = 64;
  localparam int NSLOT = 512;
  localparam int LEAF_CAP = (NSLOT + 1) / 2;
  localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int IDLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] bits;
    logic [6:0]  len;
    logic        present;
    logic [7:0]  symbol;
  } result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [87:0] out_tdata;

  always #5 clk = ~clk;

  huffman_code_builder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic [31:0] hist [NSYM];
  logic        sat_seen;
  logic [39:0] nfreq [NSLOT];
  int          nkid0 [NSLOT];
  int          nkid1 [NSLOT];
  bit          nleaf [NSLOT];
  int          nsym [NSLOT];
  int          heap [NSYM];
  bit          tab_present [NSYM];
  logic [6:0]  tab_len [NSYM];
  logic [63:0] tab_bits [NSYM];

  result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;

  task automatic heap_push(int pos, int item);
    int up;
    while (pos > 0) begin
      up = (pos - 1) >> 1;
      if (nfreq[item] >= nfreq[heap[up]]) break;
      heap[pos] = heap[up];
      pos = up;
    end
    heap[pos] = item;
  endtask

  task automatic heap_sink(int item, int n);
    int pos, ch, c;
    pos = 0;
    while (pos < (n >> 1)) begin
      ch = 2 * pos + 1;
      c = heap[ch];
      if (ch + 1 < n && nfreq[c] > nfreq[heap[ch + 1]]) begin
        ch++;
        c = heap[ch];
      end
      if (nfreq[item] <= nfreq[c]) break;
      heap[pos] = c;
      pos = ch;
    end
    heap[pos] = item;
  endtask

  task automatic heap_pop(int size, output int top);
    top = heap[0];
    if (size - 1 > 0) heap_sink(heap[size - 1], size - 1);
  endtask

  task automatic walk_codes(int root);
    int stk_node[$];
    logic [63:0] stk_bits[$];
    int stk_len[$];
    bit stk_over[$];
    int nd, len, kid;
    logic [63:0] bits;
    bit over;
    stk_node.push_back(root); stk_bits.push_back(64'd0);
    stk_len.push_back(0); stk_over.push_back(1'b0);
    while (stk_node.size() > 0) begin
      nd = stk_node.pop_back(); bits = stk_bits.pop_back();
      len = stk_len.pop_back(); over = stk_over.pop_back();
      if (nleaf[nd]) begin
        if (!over) begin
          tab_present[nsym[nd]] = 1'b1;
          tab_len[nsym[nd]] = len[6:0];
          tab_bits[nsym[nd]] = bits;
        end
        continue;
      end
      for (int b = 1; b >= 0; b--) begin
        if (stk_node.size() >= NSLOT) break;
        kid = b ? nkid1[nd] : nkid0[nd];
        stk_node.push_back(kid);
        if (over || len >= MAXLEN) begin
          stk_over.push_back(1'b1); stk_bits.push_back(64'd0); stk_len.push_back(len);
        end else begin
          stk_over.push_back(1'b0); stk_bits.push_back({bits[62:0], b[0]});
          stk_len.push_back(len + 1);
        end
      end
    end
  endtask

  task automatic build_codes(output bit empty);
    int n, size, next, a, b;
    n = 0;
    for (int s = 0; s < NSYM; s++) tab_present[s] = 1'b0;
    for (int s = 0; s < NSYM && n < LEAF_CAP; s++) begin
      if (hist[s] != 0) begin
        nfreq[n] = 40'(hist[s]); nleaf[n] = 1'b1; nsym[n] = s;
        nkid0[n] = 0; nkid1[n] = 0;
        heap_push(n, n);
        n++;
      end
    end
    empty = (n == 0);
    if (empty) return;
    size = n;
    next = n;
    while (size > 1 && next < NSLOT) begin
      heap_pop(size, a); size--;
      heap_pop(size, b); size--;
      nfreq[next] = nfreq[a] + nfreq[b];
      nleaf[next] = 1'b0; nsym[next] = 0;
      nkid0[next] = a; nkid1[next] = b;
      heap_push(size, next);
      size++; next++;
    end
    walk_codes(heap[0]);
  endtask

  task automatic predict_beat(logic [1:0] op, logic [7:0] sym);
    result_t r;
    bit empty;
    r = '0;
    r.symbol = sym;
    case (op)
      OP_COUNT: begin
        if (hist[sym] == CNT_TOP) sat_seen = 1'b1;
        else hist[sym]++;
        r.status = sat_seen ? STAT_SAT : STAT_OK;
      end
      OP_BUILD: begin
        build_codes(empty);
        r.status = empty ? STAT_EMPTY : (sat_seen ? STAT_SAT : STAT_OK);
        for (int s = 0; s < NSYM; s++) hist[s] = '0;
        sat_seen = 1'b0;
      end
      OP_READ: begin
        if (tab_present[sym]) begin
          r.present = 1'b1; r.len = tab_len[sym]; r.bits = tab_bits[sym];
        end
        r.status = sat_seen ? STAT_SAT : STAT_OK;
      end
      default: r.status = sat_seen ? STAT_SAT : STAT_OK;
    endcase
    pending_results.push_back(r);
  endtask

  task automatic random_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 55) g = 0;
    else if (g < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_beat(logic [1:0] op, logic [7:0] sym);
    random_gap();
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, sym, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(op, sym);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Saturation needs 2^32 counts of one byte and is out of reach here; this covers
  // empty builds, unknown operations and single-symbol tables.
  task automatic test_directed();
    send_beat(OP_READ, 8'd0);
    send_beat(OP_BUILD, 8'd0);
    send_beat(OP_READ, 8'd255);
    send_beat(OP_UNKNOWN, 8'hA5);
    send_beat(OP_COUNT, 8'd0);
    send_beat(OP_BUILD, 8'd0);
    send_beat(OP_READ, 8'd0);
    send_beat(OP_READ, 8'd1);
    send_beat(OP_COUNT, 8'd255);
    send_beat(OP_COUNT, 8'd255);
    send_beat(OP_COUNT, 8'd0);
    send_beat(OP_COUNT, 8'h5A);
    send_beat(OP_COUNT, 8'hA5);
    send_beat(OP_UNKNOWN, 8'hFF);
    send_beat(OP_BUILD, 8'd7);
    send_beat(OP_READ, 8'd255);
    send_beat(OP_READ, 8'd0);
    send_beat(OP_READ, 8'h5A);
    send_beat(OP_READ, 8'hA5);
    send_beat(OP_READ, 8'h11);
  endtask

  // Fibonacci-like weights drive a deep, lopsided tree with long codes.
  task automatic test_deep_tree();
    int w;
    int a, b, t;
    a = 1; b = 1;
    for (int s = 0; s < 10; s++) begin
      w = a;
      for (int k = 0; k < w; k++) send_beat(OP_COUNT, s[7:0]);
      t = a + b; a = b; b = t;
    end
    send_beat(OP_BUILD, 8'd0);
    for (int s = 0; s < 11; s++) send_beat(OP_READ, s[7:0]);
  endtask

  // All 256 symbols present, equal weights plus ties.
  task automatic test_full_alphabet();
    for (int s = 0; s < NSYM; s++) send_beat(OP_COUNT, s[7:0]);
    drain();
    send_beat(OP_BUILD, 8'd0);
    for (int s = 0; s < NSYM; s += 4) send_beat(OP_READ, s[7:0]);
  endtask

  task automatic test_random();
    int nsyms, base, cnt;
    for (int round = 0; round < 7; round++) begin
      nsyms = $urandom_range(1, 12);
      base = $urandom_range(0, 255);
      cnt = $urandom_range(5, 30);
      for (int k = 0; k < cnt; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        else
          send_beat(OP_COUNT, 8'((base + $urandom_range(0, nsyms - 1)) % NSYM));
      end
      send_beat(OP_BUILD, 8'($urandom_range(0, 255)));
      for (int k = 0; k < nsyms + 4; k++)
        send_beat(OP_READ, 8'((base + $urandom_range(0, nsyms + 1)) % NSYM));
    end
  endtask

  // result side: random stalls, in-order check
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      g = $urandom_range(0, 99);
      out_tready <= (g < 70) || (g >= 97);
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[81:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.symbol !== want.symbol) begin
          $display("%0t: symbol exp %h got %h", $time, want.symbol, got.symbol); errors++;
        end
        if (got.present !== want.present) begin
          $display("%0t: present exp %b got %b", $time, want.present, got.present); errors++;
        end
        if (got.len !== want.len) begin
          $display("%0t: code_length exp %0d got %0d", $time, want.len, got.len); errors++;
        end
        if (got.bits !== want.bits) begin
          $display("%0t: code_bits exp %h got %h", $time, want.bits, got.bits); errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NSYM; s++) begin
      hist[s] = '0; tab_present[s] = 1'b0;
    end
    sat_seen = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_deep_tree();
    drain();
    test_full_alphabet();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: huffman_code_builder.f
rtl/core/hcb_pkg.sv
rtl/core/hcb_ctrl.sv
rtl/core/hcb_dp.sv
rtl/core/huffman_code_builder.sv
tb/huffman_code_builder_test.sv
